[rtl/kie_pkg.sv]
package kie_pkg;

  localparam int MAX_WORD_LENGTH = 8;
  localparam int POSITION_BITS = 20;
  localparam int BUCKET_BITS = 2 * MAX_WORD_LENGTH;
  localparam int SUM_BITS = 48;
  localparam int LOG_BITS = 21;
  localparam int FEATURE_BITS = 21;
  localparam int LOG_FRAC_BITS = 16;
  localparam int LOG_INT_BITS = LOG_BITS - LOG_FRAC_BITS;
  localparam int MANT_BITS = 31;
  localparam int PROD_BITS = POSITION_BITS + LOG_BITS;

  localparam logic [1:0] FUNC_PUSH = 2'd0;
  localparam logic [1:0] FUNC_READ = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic CFG_KMER_LENGTH = 1'b0;
  localparam logic CFG_SEQUENCE_LENGTH = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [4:0]  residue;
    logic [15:0] bucket_select;
  } item_t;

  typedef struct packed {
    logic [15:0]             bucket;
    logic                    word_complete;
    logic                    seen;
    logic [FEATURE_BITS-1:0] feature;
  } result_t;

  typedef struct packed {
    logic                     start;
    logic [POSITION_BITS-1:0] n;
  } log_req_t;

  typedef struct packed {
    logic                done;
    logic [LOG_BITS-1:0] value;
  } log_rsp_t;

  typedef struct packed {
    logic                     valid;
    logic [POSITION_BITS-1:0] first;
    logic [POSITION_BITS-1:0] last;
    logic [SUM_BITS-1:0]      sum;
  } entry_t;

  // Letter code as a two's complement step added to the shifted index.
  function automatic logic [BUCKET_BITS-1:0] code_of(input logic [4:0] residue);
    logic [BUCKET_BITS-1:0] c;
    case (residue)
      5'd0:  c = BUCKET_BITS'(0);
      5'd2:  c = BUCKET_BITS'(1);
      5'd3:  c = BUCKET_BITS'(2);
      5'd4:  c = BUCKET_BITS'(3);
      5'd5:  c = BUCKET_BITS'(4);
      5'd6:  c = BUCKET_BITS'(5);
      5'd7:  c = BUCKET_BITS'(6);
      5'd8:  c = BUCKET_BITS'(7);
      5'd10: c = BUCKET_BITS'(8);
      5'd11: c = BUCKET_BITS'(9);
      5'd12: c = BUCKET_BITS'(10);
      5'd13: c = BUCKET_BITS'(11);
      5'd15: c = BUCKET_BITS'(12);
      5'd16: c = BUCKET_BITS'(13);
      5'd17: c = BUCKET_BITS'(14);
      5'd18: c = BUCKET_BITS'(16);
      5'd20: c = BUCKET_BITS'(17);
      5'd21: c = BUCKET_BITS'(18);
      5'd23: c = BUCKET_BITS'(19);
      5'd1, 5'd9, 5'd14, 5'd19, 5'd22, 5'd24: c = '1;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

[rtl/kie_log2.sv]
module kie_log2 (
  input  logic              clk,
  input  logic              rst,
  input  kie_pkg::log_req_t req,
  output kie_pkg::log_rsp_t rsp
);

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ} lstate_t;

  lstate_t                               state;
  logic [kie_pkg::POSITION_BITS-1:0]     x;
  logic [kie_pkg::LOG_INT_BITS-1:0]      e;
  logic [kie_pkg::MANT_BITS-1:0]         m;
  logic [3:0]                            b;
  logic [kie_pkg::LOG_FRAC_BITS-1:0]     frac;
  logic [2*kie_pkg::MANT_BITS-1:0]       sq;
  logic [kie_pkg::MANT_BITS:0]           t;
  logic [kie_pkg::LOG_FRAC_BITS-1:0]     frac_next;

  assign sq = m * m;
  assign t = sq[2*kie_pkg::MANT_BITS-1:kie_pkg::MANT_BITS-1];
  assign frac_next = t[kie_pkg::MANT_BITS]
                   ? (frac | (kie_pkg::LOG_FRAC_BITS'(1) << b)) : frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= ((state == L_IDLE) && req.start && (req.n == '0))
               || ((state == L_SQ) && (b == '0));
      case (state)
        L_IDLE: begin
          if (req.start) begin
            if (req.n == '0) begin
              rsp.value <= '0;
            end else begin
              x <= req.n;
              e <= kie_pkg::LOG_INT_BITS'(kie_pkg::POSITION_BITS - 1);
              state <= L_NORM;
            end
          end
        end
        L_NORM: begin
          if (x[kie_pkg::POSITION_BITS-1]) begin
            m <= {x, {(kie_pkg::MANT_BITS - kie_pkg::POSITION_BITS){1'b0}}};
            b <= 4'(kie_pkg::LOG_FRAC_BITS - 1);
            frac <= '0;
            state <= L_SQ;
          end else begin
            x <= x << 1;
            e <= e - 1'b1;
          end
        end
        L_SQ: begin
          m <= t[kie_pkg::MANT_BITS] ? t[kie_pkg::MANT_BITS:1] : t[kie_pkg::MANT_BITS-1:0];
          frac <= frac_next;
          b <= b - 1'b1;
          if (b == '0) begin
            rsp.value <= {e, frac_next};
            state <= L_IDLE;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

[rtl/kmer_interval_entropy.sv]
// Return-time entropy of k-letter words over a residue stream. Each word on the item
// channel is a push, a read, a clear or an unused code, and each gives exactly one
// result word. An item is taken only in the idle state, so the next item waits until
// the last one is through. A push goes straight to the emit state while fewer than k
// residues have been seen; otherwise it reads the bucket, writes a new entry or, on a
// repeat, first runs the iterative log2 unit on the gap (normalising shifts, then 16
// squarings), and then emits. A read of an unseen bucket emits after the table read; a
// read of a seen bucket with a nonzero sequence length adds two log2 runs and a 48-step
// restoring division by the sequence length. A clear and reset both sweep the whole
// table one entry per cycle. A result word not yet taken holds the block in its emit
// state. Configuration writes are taken at any time. Configure while idle.
module kmer_interval_entropy (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             item_valid,
  output logic                             item_ready,
  input  kie_pkg::item_t                   item,
  output logic                             result_valid,
  input  logic                             result_ready,
  output kie_pkg::result_t                 result,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [kie_pkg::POSITION_BITS-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PRD, S_PCALC, S_PLOG, S_PACC, S_WRITE,
    S_RRD, S_RCALC, S_RLOG, S_RACC, S_DIV, S_RLEN, S_EMIT
  } state_t;

  localparam int PB = kie_pkg::POSITION_BITS;
  localparam int BB = kie_pkg::BUCKET_BITS;

  state_t                         state;
  logic [3:0]                     kmer_length;
  logic [PB-1:0]                  sequence_length;
  logic [BB-1:0]                  rolling_index;
  logic [PB-1:0]                  residue_count;
  logic [BB-1:0]                  addr;
  logic                           clear_item;
  logic [PB-1:0]                  pos;
  logic [PB-1:0]                  dval;
  logic [kie_pkg::PROD_BITS-1:0]  prod;
  logic [kie_pkg::SUM_BITS-1:0]   num;
  logic [PB-1:0]                  rem;
  logic [5:0]                     dcnt;
  kie_pkg::result_t               res;
  kie_pkg::entry_t                wreg;
  kie_pkg::entry_t                rd;
  kie_pkg::log_req_t              lreq;
  kie_pkg::log_rsp_t              lrsp;

  kie_pkg::entry_t                mem [2**BB];
  logic                           mem_we;
  kie_pkg::entry_t                mem_wdata;

  logic [3:0]                     kw;
  logic [BB:0]                    one_sh;
  logic [BB-1:0]                  card_mask;
  logic [BB-1:0]                  index_next;
  logic [PB-1:0]                  count_next;
  logic [PB:0]                    r2;
  logic                           ge;

  always_comb begin
    if (kmer_length == 4'd0) begin
      kw = 4'd1;
    end else if (kmer_length > 4'(kie_pkg::MAX_WORD_LENGTH)) begin
      kw = 4'(kie_pkg::MAX_WORD_LENGTH);
    end else begin
      kw = kmer_length;
    end
  end

  assign one_sh = (BB+1)'(1) << {kw, 1'b0};
  assign card_mask = BB'(one_sh - (BB+1)'(1));
  assign index_next = ({rolling_index[BB-3:0], 2'b00} + kie_pkg::code_of(item.residue))
                    & card_mask;
  assign count_next = residue_count + 1'b1;
  assign r2 = {rem, num[kie_pkg::SUM_BITS-1]};
  assign ge = r2 >= {1'b0, sequence_length};

  assign item_ready = (state == S_IDLE);
  assign mem_we = (state == S_WRITE) || (state == S_CLEAR);
  assign mem_wdata = (state == S_CLEAR) ? '0 : wreg;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= mem_wdata;
    end
    rd <= mem[addr];
  end

  kie_log2 u_log2 (
    .clk (clk),
    .rst (rst),
    .req (lreq),
    .rsp (lrsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      addr <= '0;
      clear_item <= 1'b0;
      kmer_length <= 4'd1;
      sequence_length <= PB'(1);
      rolling_index <= '0;
      residue_count <= '0;
      result_valid <= 1'b0;
      lreq.start <= 1'b0;
    end else begin
      lreq.start <= ((state == S_PCALC) && rd.valid)
                 || ((state == S_RCALC) && rd.valid && (sequence_length != '0))
                 || ((state == S_DIV) && (dcnt == 6'(kie_pkg::SUM_BITS - 1)));
      if (cfg_we) begin
        case (cfg_index)
          kie_pkg::CFG_KMER_LENGTH:     kmer_length <= cfg_data[3:0];
          kie_pkg::CFG_SEQUENCE_LENGTH: sequence_length <= cfg_data;
          default: ;
        endcase
      end
      if ((state == S_EMIT) && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          addr <= addr + 1'b1;
          if (addr == '1) begin
            state <= clear_item ? S_EMIT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            clear_item <= (item.func == kie_pkg::FUNC_CLEAR);
            case (item.func)
              kie_pkg::FUNC_PUSH: begin
                rolling_index <= index_next;
                residue_count <= count_next;
                res <= '{bucket: index_next,
                         word_complete: (count_next >= {{(PB-4){1'b0}}, kw}),
                         seen: 1'b0, feature: '0};
                if (count_next >= {{(PB-4){1'b0}}, kw}) begin
                  addr <= index_next;
                  pos <= count_next - {{(PB-4){1'b0}}, kw};
                  state <= S_PRD;
                end else begin
                  state <= S_EMIT;
                end
              end
              kie_pkg::FUNC_READ: begin
                addr <= item.bucket_select;
                res <= '{bucket: item.bucket_select, word_complete: 1'b0,
                         seen: 1'b0, feature: '0};
                state <= S_RRD;
              end
              kie_pkg::FUNC_CLEAR: begin
                rolling_index <= '0;
                residue_count <= '0;
                addr <= '0;
                res <= '0;
                state <= S_CLEAR;
              end
              default: begin
                res <= '0;
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_PRD: state <= S_PCALC;
        S_PCALC: begin
          if (!rd.valid) begin
            wreg <= '{valid: 1'b1, first: pos, last: pos, sum: '0};
            state <= S_WRITE;
          end else begin
            dval <= pos - rd.last;
            lreq.n <= pos - rd.last;
            state <= S_PLOG;
          end
        end
        S_PLOG: begin
          if (lrsp.done) begin
            prod <= kie_pkg::PROD_BITS'(dval) * kie_pkg::PROD_BITS'(lrsp.value);
            state <= S_PACC;
          end
        end
        S_PACC: begin
          wreg <= '{valid: 1'b1, first: rd.first, last: pos,
                    sum: rd.sum + kie_pkg::SUM_BITS'(prod)};
          state <= S_WRITE;
        end
        S_WRITE: state <= S_EMIT;
        S_RRD: state <= S_RCALC;
        S_RCALC: begin
          if (!rd.valid) begin
            state <= S_EMIT;
          end else begin
            res.seen <= 1'b1;
            if (sequence_length == '0) begin
              state <= S_EMIT;
            end else begin
              dval <= sequence_length + rd.first - rd.last;
              lreq.n <= sequence_length + rd.first - rd.last;
              state <= S_RLOG;
            end
          end
        end
        S_RLOG: begin
          if (lrsp.done) begin
            prod <= kie_pkg::PROD_BITS'(dval) * kie_pkg::PROD_BITS'(lrsp.value);
            state <= S_RACC;
          end
        end
        S_RACC: begin
          num <= rd.sum + kie_pkg::SUM_BITS'(prod);
          rem <= '0;
          dcnt <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= ge ? PB'(r2 - {1'b0, sequence_length}) : r2[PB-1:0];
          num <= {num[kie_pkg::SUM_BITS-2:0], ge};
          dcnt <= dcnt + 1'b1;
          if (dcnt == 6'(kie_pkg::SUM_BITS - 1)) begin
            lreq.n <= sequence_length;
            state <= S_RLEN;
          end
        end
        S_RLEN: begin
          if (lrsp.done) begin
            if (kie_pkg::SUM_BITS'(lrsp.value) > num) begin
              res.feature <= kie_pkg::FEATURE_BITS'(lrsp.value - num[kie_pkg::LOG_BITS-1:0]);
            end else begin
              res.feature <= '0;
            end
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!result_valid || result_ready) begin
            result <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[tb/kie_checker.sv]
`timescale 1ns / 1ps

module kie_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_ready,
  input  kie_pkg::item_t   item,
  input  logic             result_valid,
  input  logic             result_ready,
  input  kie_pkg::result_t result,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [kie_pkg::POSITION_BITS-1:0] cfg_data,
  output int               fail_count,
  output int               pending
);

  localparam int PB = kie_pkg::POSITION_BITS;
  localparam int BB = kie_pkg::BUCKET_BITS;

  logic [3:0] word_len_reg;
  logic [PB-1:0] seq_len;
  logic [BB-1:0] roll;
  logic [PB-1:0] count;
  bit valid_tab [0:(1<<BB)-1];
  logic [PB-1:0] first_tab [0:(1<<BB)-1];
  logic [PB-1:0] last_tab [0:(1<<BB)-1];
  logic [kie_pkg::SUM_BITS-1:0] sum_tab [0:(1<<BB)-1];
  kie_pkg::result_t expected_q[$];

  function automatic logic [63:0] log2_q16(input logic [31:0] n);
    logic [63:0] m;
    logic [63:0] frac;
    int e;
    frac = 0;
    e = 0;
    if (n == 0) return 0;
    while (e < 31 && (n >> (e + 1)) != 0) e++;
    m = 64'(n) << (30 - e);
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac[b] = 1'b1;
      end
    end
    return (64'(e) << 16) | frac;
  endfunction

  function automatic int letter_step(input logic [4:0] r);
    case (r)
      5'd1, 5'd9, 5'd14, 5'd19, 5'd22, 5'd24: return -1;
      5'd18: return 16;
      5'd20: return 17;
      5'd21: return 18;
      5'd23: return 19;
      default: begin
        if (r == 0 || r > 24) return 0;
        if (r < 9) return r - 1;
        if (r < 14) return r - 2;
        return r - 3;
      end
    endcase
  endfunction

  function automatic kie_pkg::result_t predict_word(input kie_pkg::item_t it);
    kie_pkg::result_t r;
    int k;
    logic [31:0] mask, sel, dc, d, pos;
    logic [63:0] total, q, lg;
    r = '0;
    k = (word_len_reg == 0) ? 1
        : (word_len_reg > kie_pkg::MAX_WORD_LENGTH) ? kie_pkg::MAX_WORD_LENGTH
        : int'(word_len_reg);
    mask = (32'd1 << (2 * k)) - 1;
    case (it.func)
      kie_pkg::FUNC_PUSH: begin
        roll = BB'((32'(roll) * 4 + 32'(letter_step(it.residue))) & mask);
        count = count + 1'b1;
        r.bucket = roll;
        if (count >= k) begin
          pos = (32'(count) - k) & ((32'd1 << PB) - 1);
          r.word_complete = 1'b1;
          if (!valid_tab[roll]) begin
            valid_tab[roll] = 1'b1;
            first_tab[roll] = PB'(pos);
            last_tab[roll] = PB'(pos);
            sum_tab[roll] = '0;
          end else begin
            d = (pos - 32'(last_tab[roll])) & ((32'd1 << PB) - 1);
            sum_tab[roll] = sum_tab[roll] + kie_pkg::SUM_BITS'(64'(d) * log2_q16(d));
            last_tab[roll] = PB'(pos);
          end
        end
      end
      kie_pkg::FUNC_READ: begin
        sel = 32'(it.bucket_select);
        r.bucket = it.bucket_select;
        if (valid_tab[sel]) begin
          r.seen = 1'b1;
          if (seq_len != 0) begin
            dc = (32'(seq_len) + 32'(first_tab[sel]) - 32'(last_tab[sel]))
                 & ((32'd1 << PB) - 1);
            total = 64'(kie_pkg::SUM_BITS'(64'(sum_tab[sel]) + 64'(dc) * log2_q16(dc)));
            q = total / 64'(seq_len);
            lg = log2_q16(32'(seq_len));
            r.feature = kie_pkg::FEATURE_BITS'(lg > q ? lg - q : 64'd0);
          end
        end
      end
      kie_pkg::FUNC_CLEAR: begin
        roll = '0;
        count = '0;
        foreach (valid_tab[i]) valid_tab[i] = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    kie_pkg::result_t e;
    int errs;
    errs = 0;
    if (rst) begin
      word_len_reg <= 4'd1;
      seq_len <= PB'(1);
      roll = '0;
      count = '0;
      foreach (valid_tab[i]) valid_tab[i] = 1'b0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == kie_pkg::CFG_KMER_LENGTH) word_len_reg <= cfg_data[3:0];
        else seq_len <= cfg_data;
      end
      if (item_valid && item_ready) expected_q.push_back(predict_word(item));
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected: %p", result);
          errs++;
        end else begin
          e = expected_q.pop_front();
          if (e.bucket !== result.bucket) begin
            $error("bucket expected %0d actual %0d", e.bucket, result.bucket);
            errs++;
          end
          if (e.word_complete !== result.word_complete) begin
            $error("word_complete expected %0d actual %0d", e.word_complete,
                   result.word_complete);
            errs++;
          end
          if (e.seen !== result.seen) begin
            $error("seen expected %0d actual %0d", e.seen, result.seen);
            errs++;
          end
          if (e.feature !== result.feature) begin
            $error("feature expected %0d actual %0d", e.feature, result.feature);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  kie_pkg::item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  kie_pkg::result_t result;
  logic cfg_we = 1'b0;
  logic cfg_index = kie_pkg::CFG_KMER_LENGTH;
  logic [kie_pkg::POSITION_BITS-1:0] cfg_data = '0;
  int fail_count;
  int pending;
  bit calm = 1'b0;

  kmer_interval_entropy dut (.*);

  kie_checker checker_i (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    result_ready <= calm || ($urandom_range(99) >= 36);
  end

  task automatic send_word(input logic [1:0] f, input logic [4:0] r, input logic [15:0] s);
    kie_pkg::item_t it;
    it.func = f;
    it.residue = r;
    it.bucket_select = s;
    while (!calm && $urandom_range(99) < 36) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (!item_ready);
  endtask

  // Stops sending and waits until every expected result word has come back.
  task automatic drain();
    item_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [kie_pkg::POSITION_BITS-1:0] v);
    drain();
    repeat (200) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly well-formed letters, some odd ones, reads aimed at buckets likely to exist.
  task automatic random_words(input int n, input int k);
    int f;
    for (int i = 0; i < n; i++) begin
      f = $urandom_range(99);
      if (f < 70) send_word(kie_pkg::FUNC_PUSH, 5'($urandom_range(31)), 16'($urandom));
      else if (f < 93) send_word(kie_pkg::FUNC_READ, 5'($urandom),
                                 f < 85 ? 16'($urandom_range((1 << (2 * k)) - 1))
                                        : 16'($urandom));
      else if (f < 96) send_word(kie_pkg::FUNC_CLEAR, 5'($urandom), 16'($urandom));
      else send_word(2'd3, 5'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_word(kie_pkg::FUNC_READ, 5'd0, 16'hFFFF);
    for (int r = 0; r < 32; r++) send_word(kie_pkg::FUNC_PUSH, 5'(r), 16'h0);
    send_word(kie_pkg::FUNC_PUSH, 5'd0, 16'h0);
    send_word(kie_pkg::FUNC_PUSH, 5'd0, 16'h0);
    send_word(kie_pkg::FUNC_READ, 5'd31, 16'h0);
    send_word(kie_pkg::FUNC_READ, 5'd0, 16'h0013);
    send_word(2'd3, 5'd31, 16'hFFFF);
    send_word(kie_pkg::FUNC_CLEAR, 5'd0, 16'h0);
    send_word(kie_pkg::FUNC_READ, 5'd0, 16'h0);
    write_reg(kie_pkg::CFG_SEQUENCE_LENGTH, 20'd0);
    send_word(kie_pkg::FUNC_PUSH, 5'd2, 16'h0);
    send_word(kie_pkg::FUNC_READ, 5'd0, 16'h1);
    write_reg(kie_pkg::CFG_SEQUENCE_LENGTH, 20'hFFFFF);
    send_word(kie_pkg::FUNC_READ, 5'd0, 16'h1);
    write_reg(kie_pkg::CFG_KMER_LENGTH, 20'd0);
    write_reg(kie_pkg::CFG_SEQUENCE_LENGTH, 20'd40);
    random_words(150, 1);
    write_reg(kie_pkg::CFG_KMER_LENGTH, 20'd2);
    write_reg(kie_pkg::CFG_SEQUENCE_LENGTH, 20'($urandom_range(1, 1000)));
    calm = 1'b1;
    random_words(300, 2);
    calm = 1'b0;
    drain();
    write_reg(kie_pkg::CFG_KMER_LENGTH, 20'd3);
    write_reg(kie_pkg::CFG_SEQUENCE_LENGTH, 20'($urandom_range(1, 1048575)));
    random_words(400, 3);
    write_reg(kie_pkg::CFG_KMER_LENGTH, 20'd8);
    write_reg(kie_pkg::CFG_SEQUENCE_LENGTH, 20'd300);
    random_words(200, 8);
    write_reg(kie_pkg::CFG_KMER_LENGTH, 20'd15);
    write_reg(kie_pkg::CFG_SEQUENCE_LENGTH, 20'd1);
    random_words(150, 8);
    drain();
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #400ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/kie_pkg.sv
rtl/kie_log2.sv
rtl/kmer_interval_entropy.sv
tb/kie_checker.sv
tb/tb_top.sv
